>>> hw/rtl/smi_pkg.sv
// Shared types, widths and helpers of the small matrix inverse and determinant block.
package smi_pkg;

    // Default number of fraction bits of the fixed point format.
    localparam int FRAC_BITS_DEF = 16;

    // Width of one matrix entry and of one result field.
    localparam int DATA_W = 32;

    // One lane for each adjugate entry of a 3x3 matrix.
    localparam int NLANE = 9;

    // An adjugate entry is the difference of two 64-bit products.
    localparam int ADJ_W = 65;

    // The determinant is a sum of three 32 x 65-bit products, and its magnitude.
    localparam int DET_W = 99;
    localparam int MAG_W = 98;

    // Quotient bits kept by the divider; anything larger saturates.
    localparam int QUO_W = 33;

    // Active matrix dimension.
    typedef enum logic [1:0] {
        DIM_NONE = 2'd0,
        DIM_1    = 2'd1,
        DIM_2    = 2'd2,
        DIM_3    = 2'd3
    } t_dim;

    // Operands of one cofactor lane, which forms x*y - u*v.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] v;
    } t_cof;

    // Determinant in sign and magnitude form.
    typedef struct packed {
        logic             neg;
        logic             zero;
        logic [MAG_W-1:0] mag;
    } t_det;

    // Per-item side information that travels along the divider lanes.
    typedef struct packed {
        logic              singular;
        logic [DATA_W-1:0] det;
        logic [NLANE-1:0]  neg;
    } t_meta;

    // Saturates a sign and magnitude value to a signed 32-bit field.
    function automatic logic [DATA_W-1:0] sat_q(input logic neg, input logic [MAG_W-1:0] mag);
        logic [DATA_W-1:0] res;
        if (!neg) begin
            res = (mag > MAG_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[DATA_W-1:0];
        end else begin
            res = (mag > MAG_W'(32'h8000_0000)) ? 32'h8000_0000
                                                : (32'd0 - mag[DATA_W-1:0]);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/smi_if.sv
// Valid and ready channel interfaces for matrix items and result items.
interface smi_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               dim;
    logic signed [31:0]       a00;
    logic signed [31:0]       a01;
    logic signed [31:0]       a02;
    logic signed [31:0]       a10;
    logic signed [31:0]       a11;
    logic signed [31:0]       a12;
    logic signed [31:0]       a20;
    logic signed [31:0]       a21;
    logic signed [31:0]       a22;

    modport source (output valid, dim, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink (input valid, dim, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface smi_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [31:0]       b00;
    logic signed [31:0]       b01;
    logic signed [31:0]       b02;
    logic signed [31:0]       b10;
    logic signed [31:0]       b11;
    logic signed [31:0]       b12;
    logic signed [31:0]       b20;
    logic signed [31:0]       b21;
    logic signed [31:0]       b22;
    logic signed [31:0]       determinant;
    logic                     singular;

    modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                    determinant, singular, input ready);
    modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  determinant, singular, output ready);
endinterface

>>> hw/rtl/smi_cof_lane.sv
// One cofactor lane: two registered products and their registered difference.
module smi_cof_lane (
    input  logic                             i_clk,
    input  logic [1:0]                       i_en,
    input  smi_pkg::t_cof                    i_cof,
    output logic signed [smi_pkg::ADJ_W-1:0] o_adj
);

    logic signed [2*smi_pkg::DATA_W-1:0] r_pxy;
    logic signed [2*smi_pkg::DATA_W-1:0] r_puv;
    logic signed [smi_pkg::ADJ_W-1:0]    r_adj;

    // First stage: the two products.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pxy <= i_cof.x * i_cof.y;
            r_puv <= i_cof.u * i_cof.v;
        end
    end

    // Second stage: their difference at full precision.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_adj <= smi_pkg::ADJ_W'(r_pxy) - smi_pkg::ADJ_W'(r_puv);
        end
    end

    assign o_adj = r_adj;

endmodule

>>> hw/rtl/smi_det_unit.sv
// Determinant from the first row and the first adjugate column, in four stages.
module smi_det_unit (
    input  logic                              i_clk,
    input  logic [3:0]                        i_en,
    input  logic signed [smi_pkg::DATA_W-1:0] i_a0  [3],
    input  logic signed [smi_pkg::ADJ_W-1:0]  i_adj [3],
    output smi_pkg::t_det                     o_det
);

    localparam int HALF_W = smi_pkg::DATA_W;

    logic signed [smi_pkg::ADJ_W-1:0] r_ph [3];
    logic signed [smi_pkg::ADJ_W-1:0] r_pl [3];
    logic signed [smi_pkg::DET_W-1:0] r_term [3];
    logic signed [smi_pkg::DET_W-1:0] r_sum;
    logic signed [smi_pkg::DET_W-1:0] w_neg_sum;
    smi_pkg::t_det                    r_det;

    // Partial products: entry times the upper and the lower half of the adjugate.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_ph[j] <= i_a0[j] * $signed(i_adj[j][smi_pkg::ADJ_W-1:HALF_W]);
                r_pl[j] <= i_a0[j] * $signed({1'b0, i_adj[j][HALF_W-1:0]});
            end
        end
    end

    // Recombine the halves of each product.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int j = 0; j < 3; j++) begin
                r_term[j] <= (smi_pkg::DET_W'(r_ph[j]) <<< HALF_W) + smi_pkg::DET_W'(r_pl[j]);
            end
        end
    end

    // Sum of the three row terms.
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_sum <= r_term[0] + r_term[1] + r_term[2];
        end
    end

    // Sign and magnitude of the determinant.
    assign w_neg_sum = -r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_det.neg  <= r_sum[smi_pkg::DET_W-1];
            r_det.zero <= (r_sum == '0);
            r_det.mag  <= r_sum[smi_pkg::DET_W-1] ? w_neg_sum[smi_pkg::MAG_W-1:0]
                                                  : r_sum[smi_pkg::MAG_W-1:0];
        end
    end

    assign o_det = r_det;

endmodule

>>> hw/rtl/smi_div_lane.sv
// Pipelined restoring divider lane: one quotient bit per stage, with overflow detect.
module smi_div_lane #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic [smi_pkg::QUO_W:0]          i_en,
    input  logic signed [smi_pkg::ADJ_W-1:0] i_adj,
    input  logic [smi_pkg::MAG_W-1:0]        i_d [smi_pkg::QUO_W+1],
    output logic [smi_pkg::QUO_W-1:0]        o_q,
    output logic                             o_ovf
);

    localparam int QW    = smi_pkg::QUO_W;
    localparam int NUM_W = smi_pkg::ADJ_W - 1 + 2 * FRAC_BITS;
    localparam int REM_W = (NUM_W > smi_pkg::MAG_W + QW) ? NUM_W : smi_pkg::MAG_W + QW;

    logic signed [smi_pkg::ADJ_W-1:0] w_adj_neg;
    logic [smi_pkg::ADJ_W-2:0]        w_mag;
    logic [NUM_W-1:0]                 w_num;
    logic [REM_W-1:0]                 w_num_x;
    logic [REM_W-1:0]                 w_dtop;

    logic [REM_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_q   [QW+1];
    logic             r_ovf [QW+1];

    // Numerator is the adjugate magnitude scaled by two fraction widths.
    assign w_adj_neg = -i_adj;
    assign w_mag     = i_adj[smi_pkg::ADJ_W-1] ? w_adj_neg[smi_pkg::ADJ_W-2:0]
                                               : i_adj[smi_pkg::ADJ_W-2:0];
    assign w_num     = {w_mag, {(2 * FRAC_BITS){1'b0}}};
    assign w_num_x   = REM_W'(w_num);
    assign w_dtop    = REM_W'(i_d[0]) << QW;

    // Entry stage: load the remainder and flag a quotient too large to keep.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= w_num_x;
            r_q[0]   <= '0;
            r_ovf[0] <= (w_num_x >= w_dtop);
        end
    end

    // One trial subtraction per stage, most significant quotient bit first.
    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int BIT = QW - k;
        logic [REM_W:0] w_trial;
        logic           w_take;

        assign w_trial = {1'b0, r_rem[k-1]} - ({1'b0, REM_W'(i_d[k])} << BIT);
        assign w_take  = !w_trial[REM_W];

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_q[k]   <= r_q[k-1] | (QW'(w_take) << BIT);
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= w_take ? w_trial[REM_W-1:0] : r_rem[k-1];
                end
            end
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule

>>> hw/rtl/small_matrix_inverse_det.sv
// Top level: determinant and inverse of a 1x1, 2x2 or 3x3 fixed point matrix.
//
//  Port    Direction  Contents
//  i_mat   in         dim, a00..a22 (signed Q format entries)
//  o_res   out        b00..b22, determinant, singular
//
// One item enters per cycle while any stage is empty or the output takes a result;
// on its way to the result register each item passes the 33-stage quotient pipeline
// of the divider lanes. Stages hold their item while the next stage cannot move, so
// bubbles close up and the input accepts into empty stages while a result waits.
// Reset clears the stage valid bits only; the data registers are not reset.
module small_matrix_inverse_det #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smi_in_if.sink    i_mat,
    smi_out_if.source o_res
);

    localparam int QW      = smi_pkg::QUO_W;
    localparam int NL      = smi_pkg::NLANE;
    localparam int STG_DET = 2;
    localparam int STG_DIV = 6;
    localparam int NSTG    = STG_DIV + QW + 2;

    localparam logic signed [smi_pkg::DATA_W-1:0] ONE  = 32'sd1;
    localparam logic signed [smi_pkg::DATA_W-1:0] ZERO = 32'sd0;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    logic signed [smi_pkg::DATA_W-1:0] w_a [9];
    smi_pkg::t_dim                     w_dim;
    smi_pkg::t_cof                     w_cof [NL];

    logic signed [smi_pkg::DATA_W-1:0] r_a0_s0 [3];
    logic signed [smi_pkg::DATA_W-1:0] r_a0_s1 [3];
    smi_pkg::t_dim                     r_dim [STG_DIV];

    logic signed [smi_pkg::ADJ_W-1:0] w_adj     [NL];
    logic signed [smi_pkg::ADJ_W-1:0] w_adj_col [3];
    logic signed [smi_pkg::ADJ_W-1:0] r_adjc    [4][NL];

    smi_pkg::t_det                 w_det;
    logic [smi_pkg::MAG_W-1:0]     w_shift;
    logic [NL-1:0]                 w_neg;
    logic [smi_pkg::MAG_W-1:0]     r_dpipe [QW];
    logic [smi_pkg::MAG_W-1:0]     w_dvec  [QW+1];
    smi_pkg::t_meta                r_meta  [QW+1];

    logic [QW-1:0] w_q   [NL];
    logic          w_ovf [NL];

    logic [smi_pkg::DATA_W-1:0] r_b [NL];
    logic [smi_pkg::DATA_W-1:0] r_det_o;
    logic                       r_sing;

    // Builds the operands of one cofactor lane.
    function automatic smi_pkg::t_cof mk_cof(
        input logic signed [smi_pkg::DATA_W-1:0] x,
        input logic signed [smi_pkg::DATA_W-1:0] y,
        input logic signed [smi_pkg::DATA_W-1:0] u,
        input logic signed [smi_pkg::DATA_W-1:0] v
    );
        smi_pkg::t_cof c;
        c.x = x;
        c.y = y;
        c.u = u;
        c.v = v;
        return c;
    endfunction

    // Stage enables: a stage moves when it is empty or its successor moves.
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_comb begin
        for (int s = 0; s < NSTG; s++) begin
            if (w_en[s]) begin
                n_vld[s] = (s == 0) ? i_mat.valid : r_vld[(s == 0) ? 0 : s - 1];
            end else begin
                n_vld[s] = r_vld[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_mat.ready = w_en[0];

    // Input entries in row-major order.
    assign w_a[0] = i_mat.a00;
    assign w_a[1] = i_mat.a01;
    assign w_a[2] = i_mat.a02;
    assign w_a[3] = i_mat.a10;
    assign w_a[4] = i_mat.a11;
    assign w_a[5] = i_mat.a12;
    assign w_a[6] = i_mat.a20;
    assign w_a[7] = i_mat.a21;
    assign w_a[8] = i_mat.a22;
    assign w_dim  = smi_pkg::t_dim'(i_mat.dim);

    // Cofactor operands for each dimension; inactive lanes multiply zeros.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_cof[l] = '0;
        end
        unique case (w_dim)
            smi_pkg::DIM_NONE: begin
            end
            smi_pkg::DIM_1: begin
                w_cof[0] = mk_cof(ONE, ONE, ZERO, ZERO);
            end
            smi_pkg::DIM_2: begin
                w_cof[0] = mk_cof(w_a[4], ONE, ZERO, ZERO);
                w_cof[1] = mk_cof(ZERO, ZERO, w_a[1], ONE);
                w_cof[3] = mk_cof(ZERO, ZERO, w_a[3], ONE);
                w_cof[4] = mk_cof(w_a[0], ONE, ZERO, ZERO);
            end
            smi_pkg::DIM_3: begin
                w_cof[0] = mk_cof(w_a[4], w_a[8], w_a[7], w_a[5]);
                w_cof[1] = mk_cof(w_a[7], w_a[2], w_a[1], w_a[8]);
                w_cof[2] = mk_cof(w_a[1], w_a[5], w_a[4], w_a[2]);
                w_cof[3] = mk_cof(w_a[6], w_a[5], w_a[3], w_a[8]);
                w_cof[4] = mk_cof(w_a[0], w_a[8], w_a[6], w_a[2]);
                w_cof[5] = mk_cof(w_a[3], w_a[2], w_a[0], w_a[5]);
                w_cof[6] = mk_cof(w_a[3], w_a[7], w_a[6], w_a[4]);
                w_cof[7] = mk_cof(w_a[6], w_a[1], w_a[0], w_a[7]);
                w_cof[8] = mk_cof(w_a[0], w_a[4], w_a[3], w_a[1]);
            end
        endcase
    end

    // Adjugate lanes.
    for (genvar l = 0; l < NL; l++) begin : g_cof
        smi_cof_lane u_cof (
            .i_clk (i_clk),
            .i_en  (w_en[1:0]),
            .i_cof (w_cof[l]),
            .o_adj (w_adj[l])
        );
    end

    // First row and dimension follow the adjugate stages.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a0_s0[0] <= w_a[0];
            r_a0_s0[1] <= w_a[1];
            r_a0_s0[2] <= w_a[2];
            r_dim[0]   <= w_dim;
        end
        if (w_en[1]) begin
            r_a0_s1 <= r_a0_s0;
        end
        for (int s = 1; s < STG_DIV; s++) begin
            if (w_en[s]) begin
                r_dim[s] <= r_dim[s-1];
            end
        end
    end

    // Adjugate entries wait while the determinant is formed.
    always_ff @(posedge i_clk) begin
        if (w_en[STG_DET]) begin
            r_adjc[0] <= w_adj;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_en[STG_DET+k]) begin
                r_adjc[k] <= r_adjc[k-1];
            end
        end
    end

    // Determinant: first row times the first adjugate column.
    assign w_adj_col[0] = w_adj[0];
    assign w_adj_col[1] = w_adj[3];
    assign w_adj_col[2] = w_adj[6];

    smi_det_unit u_det (
        .i_clk (i_clk),
        .i_en  (w_en[STG_DET+3:STG_DET]),
        .i_a0  (r_a0_s1),
        .i_adj (w_adj_col),
        .o_det (w_det)
    );

    // Determinant output scaled back to one fraction width.
    always_comb begin
        unique case (r_dim[STG_DIV-1])
            smi_pkg::DIM_NONE: w_shift = '0;
            smi_pkg::DIM_1:    w_shift = w_det.mag;
            smi_pkg::DIM_2:    w_shift = w_det.mag >> FRAC_BITS;
            smi_pkg::DIM_3:    w_shift = w_det.mag >> (2 * FRAC_BITS);
        endcase
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_neg[l] = r_adjc[3][l][smi_pkg::ADJ_W-1] ^ w_det.neg;
        end
    end

    // Side information and the shared divisor travel along the divider.
    always_ff @(posedge i_clk) begin
        if (w_en[STG_DIV]) begin
            r_meta[0].singular <= w_det.zero;
            r_meta[0].det      <= smi_pkg::sat_q(w_det.neg, w_shift);
            r_meta[0].neg      <= w_neg;
            r_dpipe[0]         <= w_det.mag;
        end
        for (int k = 1; k <= QW; k++) begin
            if (w_en[STG_DIV+k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
        for (int k = 1; k < QW; k++) begin
            if (w_en[STG_DIV+k]) begin
                r_dpipe[k] <= r_dpipe[k-1];
            end
        end
    end

    always_comb begin
        w_dvec[0] = w_det.mag;
        for (int k = 1; k <= QW; k++) begin
            w_dvec[k] = r_dpipe[k-1];
        end
    end

    // Divider lanes, one per inverse entry.
    for (genvar l = 0; l < NL; l++) begin : g_div
        smi_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en[STG_DIV+QW:STG_DIV]),
            .i_adj (r_adjc[3][l]),
            .i_d   (w_dvec),
            .o_q   (w_q[l]),
            .o_ovf (w_ovf[l])
        );
    end

    // Merge stage: saturate the quotients and clear them for a singular matrix.
    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            for (int l = 0; l < NL; l++) begin
                if (r_meta[QW].singular) begin
                    r_b[l] <= '0;
                end else if (w_ovf[l]) begin
                    r_b[l] <= smi_pkg::sat_q(r_meta[QW].neg[l],
                                             smi_pkg::MAG_W'(1) << QW);
                end else begin
                    r_b[l] <= smi_pkg::sat_q(r_meta[QW].neg[l], smi_pkg::MAG_W'(w_q[l]));
                end
            end
            r_det_o <= r_meta[QW].det;
            r_sing  <= r_meta[QW].singular;
        end
    end

    assign o_res.valid       = r_vld[NSTG-1];
    assign o_res.b00         = r_b[0];
    assign o_res.b01         = r_b[1];
    assign o_res.b02         = r_b[2];
    assign o_res.b10         = r_b[3];
    assign o_res.b11         = r_b[4];
    assign o_res.b12         = r_b[5];
    assign o_res.b20         = r_b[6];
    assign o_res.b21         = r_b[7];
    assign o_res.b22         = r_b[8];
    assign o_res.determinant = r_det_o;
    assign o_res.singular    = r_sing;

`ifndef NO_ASSERTIONS
    // A singular result carries a zero determinant and a zero inverse.
    a_singular_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.singular) |->
            (o_res.determinant == 0 && o_res.b00 == 0 && o_res.b01 == 0 &&
             o_res.b02 == 0 && o_res.b10 == 0 && o_res.b11 == 0 && o_res.b12 == 0 &&
             o_res.b20 == 0 && o_res.b21 == 0 && o_res.b22 == 0))
        else $error("singular result with nonzero fields");

    // With the output stage empty the pipeline must take an item.
    a_ready_when_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_mat.ready)
        else $error("input stalled while output stage is empty");

    // No result appears in the cycle after reset.
    a_empty_after_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> bench/tb_top.sv
// Testbench for the small matrix inverse and determinant block.
`timescale 1ns / 1ps

module tb_top;

    localparam int FB = smi_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 41;

    // One matrix item and one result item.
    typedef struct {
        logic [1:0]         dim;
        logic signed [31:0] a [3][3];
    } t_matrix;

    typedef struct {
        logic signed [31:0] b [3][3];
        logic signed [31:0] det;
        logic               singular;
    } t_inverse;

    logic i_clk;
    logic i_rst_n;

    smi_in_if  mat_ch ();
    smi_out_if res_ch ();

    small_matrix_inverse_det #(.FRAC_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch.sink),
        .o_res   (res_ch.source)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_inverse expected_q [$];
    int       n_errors;
    int       n_sent;
    int       n_checked;
    int       n_singular;
    int       n_saturated;
    int       hold_cycles;
    bit       stall_enable;

    // Saturates a sign and magnitude quotient to 32 bits.
    function automatic logic signed [31:0] clamp_q(input bit neg,
                                                   input logic [255:0] mag);
        if (!neg) begin
            return (mag > 256'h7fff_ffff) ? 32'sh7fff_ffff : mag[31:0];
        end
        return (mag > 256'h8000_0000) ? 32'sh8000_0000 : 32'd0 - mag[31:0];
    endfunction

    // Exact determinant and adjugate, then the inverse by long division.
    function automatic t_inverse invert_matrix(input t_matrix m);
        t_inverse           r;
        logic signed [255:0] adj [3][3];
        logic signed [255:0] e [3][3];
        logic signed [255:0] d;
        logic [255:0]        dmag;
        logic [255:0]        num;
        int                  n;
        bit                  dneg;
        n = m.dim;
        d = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                e[i][j] = m.a[i][j];
                adj[i][j] = 0;
                r.b[i][j] = 0;
            end
        end
        r.det = 0;
        r.singular = 1'b0;
        if (n == 1) begin
            adj[0][0] = 1;
            d = e[0][0];
        end else if (n == 2) begin
            adj[0][0] = e[1][1];
            adj[0][1] = -e[0][1];
            adj[1][0] = -e[1][0];
            adj[1][1] = e[0][0];
            d = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        end else if (n == 3) begin
            adj[0][0] = e[1][1] * e[2][2] - e[2][1] * e[1][2];
            adj[0][1] = -(e[0][1] * e[2][2] - e[2][1] * e[0][2]);
            adj[0][2] = e[0][1] * e[1][2] - e[1][1] * e[0][2];
            adj[1][0] = -(e[1][0] * e[2][2] - e[2][0] * e[1][2]);
            adj[1][1] = e[0][0] * e[2][2] - e[2][0] * e[0][2];
            adj[1][2] = -(e[0][0] * e[1][2] - e[1][0] * e[0][2]);
            adj[2][0] = e[1][0] * e[2][1] - e[2][0] * e[1][1];
            adj[2][1] = -(e[0][0] * e[2][1] - e[2][0] * e[0][1]);
            adj[2][2] = e[0][0] * e[1][1] - e[1][0] * e[0][1];
            d = e[0][0] * adj[0][0] + e[0][1] * adj[1][0] + e[0][2] * adj[2][0];
        end
        if (n == 0 || d == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dneg = d < 0;
        dmag = dneg ? -d : d;
        r.det = clamp_q(dneg, dmag >> ((n - 1) * FB));
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (adj[i][j] != 0) begin
                    num = (adj[i][j] < 0) ? -adj[i][j] : adj[i][j];
                    num = num << (2 * FB);
                    r.b[i][j] = clamp_q((adj[i][j] < 0) != dneg, num / dmag);
                end
            end
        end
        return r;
    endfunction

    // Sends one matrix item and records its expected result; valid stays high.
    task automatic send_matrix(input t_matrix m);
        mat_ch.valid <= 1'b1;
        mat_ch.dim <= m.dim;
        mat_ch.a00 <= m.a[0][0]; mat_ch.a01 <= m.a[0][1]; mat_ch.a02 <= m.a[0][2];
        mat_ch.a10 <= m.a[1][0]; mat_ch.a11 <= m.a[1][1]; mat_ch.a12 <= m.a[1][2];
        mat_ch.a20 <= m.a[2][0]; mat_ch.a21 <= m.a[2][1]; mat_ch.a22 <= m.a[2][2];
        do @(posedge i_clk); while (!mat_ch.ready);
        expected_q.push_back(invert_matrix(m));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Sender idles between bursts of random length.
    int burst_left;
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                mat_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
    endtask

    // Entry values: extremes, small values near one, or fully random.
    function automatic logic signed [31:0] pick_entry();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 0;
            3, 4: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            5: return $signed($urandom_range(0, 255)) - 128;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_matrix random_matrix(input int dim_lo);
        t_matrix m;
        m.dim = 2'($urandom_range(dim_lo, 3));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m.a[i][j] = pick_entry();
        // Make some matrices singular by copying a row.
        if ($urandom_range(0, 9) == 0) m.a[1] = m.a[0];
        return m;
    endfunction

    function automatic t_matrix fill_matrix(input logic [1:0] dim,
                                            input logic signed [31:0] v);
        t_matrix m;
        m.dim = dim;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m.a[i][j] = v;
        return m;
    endfunction

    // Stops offering items and waits until every expected result has come.
    task automatic wait_drained();
        mat_ch.valid <= 1'b0;
        do @(negedge i_clk); while (expected_q.size() != 0);
    endtask

    // Directed: identity, extremes, singular, tiny determinant, dimension zero.
    task automatic test_directed();
        t_matrix m;
        for (int d = 0; d < 4; d++) begin
            m = fill_matrix(2'(d), 32'sh7fff_ffff);
            for (int i = 0; i < 3; i++) m.a[i][i] = 32'sh0001_0000;
            m.a[0][1] = 0; m.a[0][2] = 0; m.a[1][0] = 0;
            m.a[1][2] = 0; m.a[2][0] = 0; m.a[2][1] = 0;
            send_matrix(m);
            send_matrix(fill_matrix(2'(d), 32'sh8000_0000));
            send_matrix(fill_matrix(2'(d), 32'sh7fff_ffff));
            send_matrix(fill_matrix(2'(d), 0));
        end
        send_matrix(fill_matrix(smi_pkg::DIM_1, 1));
        send_matrix(fill_matrix(smi_pkg::DIM_1, -1));
        send_matrix(fill_matrix(smi_pkg::DIM_1, 32'sh0000_8000));
        m = fill_matrix(smi_pkg::DIM_2, 0);
        m.a[0][0] = 1; m.a[1][1] = 1;
        send_matrix(m);
        m = fill_matrix(smi_pkg::DIM_3, 0);
        m.a[0][0] = 32'sh8000_0000; m.a[1][1] = 32'sh8000_0000;
        m.a[2][2] = 32'sh7fff_ffff; m.a[0][2] = -1;
        send_matrix(m);
        wait_drained();
    endtask

    // Random matrices streamed in bursts.
    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) begin
            pace_sender();
            send_matrix(random_matrix($urandom_range(0, 19) == 0 ? 0 : 1));
        end
    endtask

    // Receiver holds off long enough to fill the pipeline and stall the input.
    task automatic test_backpressure();
        hold_cycles = 150;
        for (int k = 0; k < 80; k++) send_matrix(random_matrix(1));
        wait_drained();
    endtask

    // Receiver: random stall pattern, long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            res_ch.ready <= 1'b0;
        end else if (stall_enable) begin
            res_ch.ready <= ($urandom_range(0, 3) != 0);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_inverse exp_r;
        logic signed [31:0] got [3][3];
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got[0][0] = res_ch.b00; got[0][1] = res_ch.b01; got[0][2] = res_ch.b02;
            got[1][0] = res_ch.b10; got[1][1] = res_ch.b11; got[1][2] = res_ch.b12;
            got[2][0] = res_ch.b20; got[2][1] = res_ch.b21; got[2][2] = res_ch.b22;
            if (expected_q.size() == 0) begin
                $error("result with no matrix outstanding");
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                n_checked++;
                if (exp_r.singular) n_singular++;
                if (exp_r.det == 32'sh7fff_ffff || exp_r.det == 32'sh8000_0000)
                    n_saturated++;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        if (got[i][j] !== exp_r.b[i][j]) begin
                            $error("b%0d%0d: expected %0d, got %0d",
                                   i, j, exp_r.b[i][j], got[i][j]);
                            n_errors++;
                        end
                    end
                end
                if (res_ch.determinant !== exp_r.det) begin
                    $error("determinant: expected %0d, got %0d",
                           exp_r.det, res_ch.determinant);
                    n_errors++;
                end
                if (res_ch.singular !== exp_r.singular) begin
                    $error("singular: expected %0b, got %0b",
                           exp_r.singular, res_ch.singular);
                    n_errors++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        n_errors = 0; n_sent = 0; n_checked = 0; n_singular = 0; n_saturated = 0;
        hold_cycles = 0; stall_enable = 1'b0; burst_left = 0;
        i_rst_n = 1'b0;
        mat_ch.valid = 1'b0;
        mat_ch.dim = '0;
        mat_ch.a00 = '0; mat_ch.a01 = '0; mat_ch.a02 = '0;
        mat_ch.a10 = '0; mat_ch.a11 = '0; mat_ch.a12 = '0;
        mat_ch.a20 = '0; mat_ch.a21 = '0; mat_ch.a22 = '0;
        res_ch.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(300);
        stall_enable = 1'b1;
        test_random(700);
        test_backpressure();
        test_random(350);
        wait_drained();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d matrices, checked %0d results (%0d singular, %0d saturated det).",
                 n_sent, n_checked, n_singular, n_saturated);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
